// File: sv/sparse_vector_table_packer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse vector table packer
// Shared helpers for concurrent checks, clocked forms with and without reset guard.
// ----------------------------------------------------------------------------
`ifndef SPARSE_VECTOR_TABLE_PACKER_TOP_DEFINES_SVH
`define SPARSE_VECTOR_TABLE_PACKER_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define SVTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included
`define SVTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/svtp_pkg.sv
// ----------------------------------------------------------------------------
// svtp_pkg
// Sizes, opcodes and result kinds of the sparse vector table packer.
// ----------------------------------------------------------------------------
`default_nettype none
package svtp_pkg;
  localparam int TableDepth = 32768;
  localparam int VectorMax  = 256;
  localparam int IndexMax   = 4095;
  localparam int AddrW      = 15;
  localparam int IdxW       = 12;
  localparam int TgtW       = 15;
  localparam int CntW       = 9;
  localparam int StgW       = 8;
  localparam int BaseW      = 16;
  localparam int UsedW      = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // One table slot: idx is the stored index (the check), valid marks a written slot
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic [TgtW-1:0] tgt;
  } slot_t;
endpackage
`default_nettype wire

// File: sv/svtp_slot_ram.sv
// ----------------------------------------------------------------------------
// svtp_slot_ram
// Packed table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module svtp_slot_ram
  import svtp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire slot_t            wdata,
  input  wire logic [AddrW-1:0] raddr,
  output slot_t                 rdata
);
  slot_t mem [TableDepth];

  // Synchronous write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/sparse_vector_table_packer_top.sv
// ----------------------------------------------------------------------------
// sparse_vector_table_packer_top
// Row-displacement packer of sparse vectors into one shared table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one base flag a cycle, and one
// slot a cycle while slots remain) before in_tready rises. Elements of a
// vector may follow back to back. A read request passes through S_RD and
// S_RDW; its result is then offered in S_OUT, and the next request is taken
// once the result is accepted. A placement first passes over the staged
// elements for the smallest and largest index (S_MM, S_MMW per element), then
// walks candidate bases: S_CAND tests the table bound (base zero is skipped
// there), S_UCHK and S_SCHK fetch the base flag, and S_SCHK and S_SWAIT read
// the slot of each staged element, stopping at the first occupied slot.
// Writing the vector takes S_WR and S_WRW per element and the scan for the
// lowest free slot S_FREE and S_FWAIT per slot stepped over. Every result
// holds until out_tready and no request is taken meanwhile. The steps follow
// from the registered reads of the slot and base flag memories.
`default_nettype none
`include "sparse_vector_table_packer_top_defines.svh"
module sparse_vector_table_packer_top
  import svtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // element_index, element_target, read_address
  input  wire logic        in_tlast,  // last_of_vector
  input  wire logic        in_tuser,  // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // placed_base, overflow, entry_target,
                                      // entry_check, high_water
  output logic             out_tuser  // result_kind
);
  localparam logic [3:0] S_CLR   = 4'd0, S_IDLE  = 4'd1, S_RD    = 4'd2,
                         S_RDW   = 4'd3, S_MM    = 4'd4, S_CAND  = 4'd5,
                         S_UCHK  = 4'd6, S_SCHK  = 4'd7, S_SWAIT = 4'd8,
                         S_WR    = 4'd9, S_FREE  = 4'd10, S_FWAIT = 4'd11,
                         S_OUT   = 4'd12, S_MMW  = 4'd13, S_WRW  = 4'd14;

  logic [3:0] state_r, state_nxt;

  // Staging memories
  logic [IdxW-1:0] stg_idx [VectorMax];
  logic [TgtW-1:0] stg_tgt [VectorMax];
  logic [IdxW-1:0] stg_idx_q;
  logic [TgtW-1:0] stg_tgt_q;
  logic [StgW-1:0] stg_ra;
  logic            stg_we;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // Base flag memory
  logic            used_mem [TableDepth + IndexMax + 1];
  logic            used_q, used_we, used_wd;
  logic [UsedW-1:0] used_wa, used_ra;

  // Slot memory
  logic             slot_we;
  logic [AddrW-1:0] slot_wa, slot_ra;
  slot_t            slot_wd, slot_q;

  logic [AddrW:0]    lf_r, lf_nxt;
  logic [AddrW-1:0]  hw_r, hw_nxt;
  logic [IdxW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [17:0] base_r, base_nxt;
  logic [CntW-1:0]   k_r, k_nxt;
  logic [UsedW:0]    clr_r, clr_nxt;
  logic [63:0]       od_r, od_nxt;
  logic [AddrW-1:0]  ra_r, ra_nxt;

  logic [IdxW-1:0]   in_idx;
  logic signed [17:0] loc;

  assign in_idx  = in_tdata[11:0];
  assign loc     = base_r + $signed({6'd0, stg_idx_q});

  svtp_slot_ram u_ram (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
    .raddr(slot_ra), .rdata(slot_q)
  );

  // Staging and base flag memories
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_idx[cnt_r[StgW-1:0]] <= in_idx;
      stg_tgt[cnt_r[StgW-1:0]] <= in_tdata[26:12];
    end
    stg_idx_q <= stg_idx[stg_ra];
    stg_tgt_q <= stg_tgt[stg_ra];
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_q <= used_mem[used_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; lf_nxt = lf_r; hw_nxt = hw_r;
    lo_nxt = lo_r; hi_nxt = hi_r; base_nxt = base_r; k_nxt = k_r;
    clr_nxt = clr_r; od_nxt = od_r; ra_nxt = ra_r;
    stg_we = 1'b0; stg_ra = k_r[StgW-1:0];
    used_we = 1'b0; used_wd = 1'b0; used_wa = '0;
    used_ra = UsedW'(base_r + 18'sd4095);
    slot_we = 1'b0; slot_wa = clr_r[AddrW-1:0];
    slot_wd = '{valid: 1'b0, idx: '0, tgt: '0};
    slot_ra = loc[AddrW-1:0];
    in_tready = 1'b0;
    unique case (state_r)
      S_CLR: begin
        slot_we = (clr_r < 17'(TableDepth));
        used_we = 1'b1; used_wa = clr_r[UsedW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == 17'(TableDepth + IndexMax)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_READ) begin
            ra_nxt = in_tdata[41:27];
            state_nxt = S_RD;
          end else begin
            if (cnt_r < 9'(VectorMax)) begin
              stg_we = 1'b1; cnt_nxt = cnt_r + 1'b1;
            end
            if (in_tlast) begin
              k_nxt = '0; state_nxt = S_MM;
            end
          end
        end
      end
      S_RD: begin slot_ra = ra_r; state_nxt = S_RDW; end
      S_RDW: begin
        od_nxt = {4'd0, hw_r, slot_q.valid ? {1'b0, slot_q.idx} : 13'h1fff,
                  slot_q.valid ? slot_q.tgt : 15'd0, 1'b0, 16'd0};
        state_nxt = S_OUT;
      end
      S_MM: begin
        stg_ra = k_r[StgW-1:0]; state_nxt = S_MMW;
      end
      S_MMW: begin
        // Running min and max over staged indexes
        if (k_r == '0 || stg_idx_q < lo_r) lo_nxt = stg_idx_q;
        if (k_r == '0 || stg_idx_q > hi_r) hi_nxt = stg_idx_q;
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 >= cnt_r) begin
          base_nxt = $signed({1'b0, lf_r}) - $signed({6'd0,
                     (k_r == '0 || stg_idx_q < lo_r) ? stg_idx_q : lo_r});
          state_nxt = S_CAND;
        end else state_nxt = S_MM;
      end
      S_CAND: begin
        k_nxt = '0;
        if (base_r > 18'sd32767 - $signed({6'd0, hi_r})) begin
          state_nxt = S_OUT;
          od_nxt = {4'd0, hw_r, 13'd0, 15'd0, 1'b1, 16'd0};
          cnt_nxt = '0;
        end else if (base_r == 18'sd0) base_nxt = base_r + 18'sd1;
        else state_nxt = S_UCHK;
      end
      S_UCHK: begin stg_ra = '0; state_nxt = S_SCHK; end
      S_SCHK: begin
        // used_q and stg_idx_q valid here; issue slot read
        if (k_r == '0 && used_q) begin
          base_nxt = base_r + 18'sd1; state_nxt = S_CAND;
        end else state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (slot_q.valid) begin
          base_nxt = base_r + 18'sd1; state_nxt = S_CAND;
        end else if (k_r + 1'b1 >= cnt_r) begin
          k_nxt = '0; state_nxt = S_WR;
        end else begin
          k_nxt = k_r + 1'b1; stg_ra = StgW'(k_r + 1'b1); state_nxt = S_SCHK;
        end
      end
      S_WR: begin stg_ra = k_r[StgW-1:0]; state_nxt = S_WRW; end
      S_WRW: begin
        slot_we = 1'b1; slot_wa = loc[AddrW-1:0];
        slot_wd = '{valid: 1'b1, idx: stg_idx_q, tgt: stg_tgt_q};
        if (loc[AddrW-1:0] > hw_r) hw_nxt = loc[AddrW-1:0];
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 >= cnt_r) begin
          used_we = 1'b1; used_wd = 1'b1;
          used_wa = UsedW'(base_r + 18'sd4095);
          state_nxt = S_FREE;
        end else state_nxt = S_WR;
      end
      S_FREE: begin
        slot_ra = lf_r[AddrW-1:0];
        if (lf_r >= 16'(TableDepth)) begin
          state_nxt = S_OUT; cnt_nxt = '0;
          od_nxt = {4'd0, hw_r, 13'd0, 15'd0, 1'b0, base_r[15:0]};
        end else state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (slot_q.valid) lf_nxt = lf_r + 1'b1;
        else begin
          state_nxt = S_OUT; cnt_nxt = '0;
          od_nxt = {4'd0, hw_r, 13'd0, 15'd0, 1'b0, base_r[15:0]};
        end
        if (slot_q.valid) state_nxt = S_FREE;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; cnt_r <= '0; lf_r <= '0; hw_r <= '0; clr_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; lf_r <= lf_nxt; hw_r <= hw_nxt;
      clr_r <= clr_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; base_r <= base_nxt; k_r <= k_nxt;
    od_r <= od_nxt; ra_r <= ra_nxt;
  end

  // Result kind follows the request that caused it
  logic kind_r;
  always_ff @(posedge clk) begin
    if (state_r == S_RDW) kind_r <= KIND_READ;
    else if (state_r == S_MMW) kind_r <= KIND_PLACE;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = od_r;
  assign out_tuser  = kind_r;

  `SVTP_ASSERT(a_busy_no_ready, (state_r != S_IDLE) |-> !in_tready, "ready while busy")
  `SVTP_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped")
  `SVTP_ASSERT(a_lf_mono, $past(rst_n) |-> (lf_r >= $past(lf_r)), "lowest free fell")
endmodule
`default_nettype wire

// File: test/sparse_vector_table_packer_top_tb.sv
// ----------------------------------------------------------------------------
// Sparse vector table packer testbench
// Streams sparse vectors and slot reads into the packer and checks every
// result against a table model kept here (or a directed value), with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sparse_vector_table_packer_top_tb;
  import svtp_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int LongHold   = 2000;

  typedef struct {
    logic        kind;
    logic [15:0] base;
    logic        ovf;
    logic [14:0] etgt;
    logic [12:0] echk;
    logic [14:0] hw;
  } result_t;

  typedef struct {
    logic    op;
    int      idx;
    int      tgt;
    logic    last;
    int      addr;
    bit      typed;
    result_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // element_index, element_target, read_address
  logic        in_tlast = 1'b0; // last_of_vector
  logic        in_tuser = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // placed_base, overflow, entry_target,
                                // entry_check, high_water
  logic        out_tuser;       // result_kind

  // Table model
  int unsigned stage_idx [VectorMax];
  int unsigned stage_tgt [VectorMax];
  int unsigned stage_cnt;
  logic [14:0] tbl_tgt   [TableDepth];
  int          tbl_chk   [TableDepth];
  bit          base_taken[TableDepth + IndexMax + 1];
  int          low_free;
  int          top_slot;

  result_t expected_q[$];
  int      errs = 0;
  longint  cycles = 0;
  bit      long_hold_req = 1'b0;
  bit      long_hold_done = 1'b0;
  int      hold_left = 0;
  int      stall_left = 0;
  int      n_place = 0, n_read = 0, n_ovf = 0;
  row_t    rows[$];

  sparse_vector_table_packer_top DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Work out the result of one accepted request and update the table
  function automatic bit pack_predict(input logic op, input int idx, input int tgt,
                                      input logic last, input int addr,
                                      output result_t r);
    int lo, hi, b, lim;
    bit fits;
    r = '{kind: KIND_READ, base: 16'd0, ovf: 1'b0, etgt: 15'd0, echk: 13'h1FFF,
          hw: top_slot[14:0]};
    if (op == OP_READ) begin
      if (addr < TableDepth) begin
        r.etgt = tbl_tgt[addr];
        r.echk = tbl_chk[addr][12:0];
      end
      n_read++;
      return 1'b1;
    end
    if (idx > IndexMax) idx = IndexMax;
    if (stage_cnt < VectorMax) begin
      stage_idx[stage_cnt] = idx;
      stage_tgt[stage_cnt] = tgt;
      stage_cnt++;
    end
    if (!last) return 1'b0;
    lo = stage_idx[0];
    hi = stage_idx[0];
    for (int k = 1; k < stage_cnt; k++) begin
      if (stage_idx[k] < lo) lo = stage_idx[k];
      if (stage_idx[k] > hi) hi = stage_idx[k];
    end
    b = low_free - lo;
    lim = TableDepth - 1 - hi;
    r.kind = KIND_PLACE;
    r.echk = 13'd0;
    // Walk candidate bases until one fits or the table runs out
    forever begin
      if (b > lim) begin
        r.ovf = 1'b1;
        n_ovf++;
        break;
      end
      if (b != 0 && !base_taken[b + IndexMax]) begin
        fits = 1'b1;
        for (int k = 0; fits && k < stage_cnt; k++)
          if (tbl_chk[b + stage_idx[k]] != -1) fits = 1'b0;
        if (fits) begin
          for (int k = 0; k < stage_cnt; k++) begin
            tbl_tgt[b + stage_idx[k]] = stage_tgt[k][14:0];
            tbl_chk[b + stage_idx[k]] = stage_idx[k];
            if (b + stage_idx[k] > top_slot) top_slot = b + stage_idx[k];
          end
          base_taken[b + IndexMax] = 1'b1;
          while (low_free < TableDepth && tbl_chk[low_free] != -1) low_free++;
          r.base = b[15:0];
          break;
        end
      end
      b++;
    end
    stage_cnt = 0;
    r.hw = top_slot[14:0];
    n_place++;
    return 1'b1;
  endfunction

  // Offer one request, hold it until accepted, then idle at random
  task automatic send_request(input logic op, input int idx, input int tgt,
                              input logic last, input int addr,
                              input bit typed, input result_t tres);
    result_t r;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {6'd0, addr[14:0], tgt[14:0], idx[11:0]};
    do @(posedge clk); while (!in_tready);
    if (pack_predict(op, idx, tgt, last, addr, r))
      expected_q.push_back(typed ? tres : r);
    gap = 0;
    if (!cycles[10] && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic op, input int idx, input logic last,
                             input int addr);
    result_t none;
    none = '{default: '0};
    send_request(op, idx, $urandom_range(0, 32767), last, addr, 1'b0, none);
  endtask

  // Check results and drive the receiver's ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result kind=%0d data=%h", out_tuser, out_tdata);
          errs++;
        end else begin
          automatic result_t e = expected_q.pop_front();
          if (out_tuser !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, out_tuser); errs++;
          end
          if (out_tdata[15:0] !== e.base) begin
            $error("placed_base exp %h got %h", e.base, out_tdata[15:0]); errs++;
          end
          if (out_tdata[16] !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, out_tdata[16]); errs++;
          end
          if (out_tdata[31:17] !== e.etgt) begin
            $error("entry_target exp %h got %h", e.etgt, out_tdata[31:17]); errs++;
          end
          if (out_tdata[44:32] !== e.echk) begin
            $error("entry_check exp %h got %h", e.echk, out_tdata[44:32]); errs++;
          end
          if (out_tdata[59:45] !== e.hw) begin
            $error("high_water exp %h got %h", e.hw, out_tdata[59:45]); errs++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!cycles[9] && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    int len, idx, addr;
    result_t rd0, none;
    bit drained;
    none = '{default: '0};
    rd0 = '{kind: KIND_READ, base: 16'd0, ovf: 1'b0, etgt: 15'd0, echk: 13'h1FFF,
            hw: 15'd0};
    drained = 1'b0;
    stage_cnt = 0;
    low_free = 0;
    top_slot = 0;
    for (int i = 0; i < TableDepth; i++) begin
      tbl_tgt[i] = '0;
      tbl_chk[i] = -1;
    end

    // Directed requests: empty table, extremes, repeated index, bit patterns
    rows.push_back('{OP_READ, 0, 0, 1'b0, 0, 1'b1, rd0});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 32767, 1'b1, rd0});
    rows.push_back('{OP_LOAD, 0, 5, 1'b1, 0, 1'b1,
                     '{KIND_PLACE, 16'd1, 1'b0, 15'd0, 13'd0, 15'd1}});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 1, 1'b1,
                     '{KIND_READ, 16'd0, 1'b0, 15'd5, 13'd0, 15'd1}});
    rows.push_back('{OP_LOAD, 4095, 32767, 1'b1, 0, 1'b1,
                     '{KIND_PLACE, 16'hF001, 1'b0, 15'd0, 13'd0, 15'd1}});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 0, 1'b1,
                     '{KIND_READ, 16'd0, 1'b0, 15'd32767, 13'd4095, 15'd1}});
    rows.push_back('{OP_LOAD, 3, 100, 1'b0, 0, 1'b0, none});
    rows.push_back('{OP_LOAD, 5, 200, 1'b0, 0, 1'b0, none});
    rows.push_back('{OP_LOAD, 5, 300, 1'b1, 0, 1'b0, none});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 2, 1'b0, none});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 4, 1'b0, none});
    rows.push_back('{OP_LOAD, 4095, 0, 1'b1, 0, 1'b0, none});
    rows.push_back('{OP_LOAD, 0, 32767, 1'b0, 0, 1'b0, none});
    rows.push_back('{OP_LOAD, 4095, 1, 1'b1, 0, 1'b0, none});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 32767, 1'b0, none});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 4095, 1'b0, none});
    rows.push_back('{OP_LOAD, 'hAAA, 'h5555, 1'b1, 'h2AAA, 1'b0, none});
    rows.push_back('{OP_LOAD, 'h555, 'h2AAA, 1'b1, 'h5555, 1'b0, none});
    rows.push_back('{OP_READ, 'hFFF, 'h7FFF, 1'b1, 'h2AAA, 1'b0, none});
    rows.push_back('{OP_READ, 0, 0, 1'b0, 'h5555, 1'b0, none});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_request(rows[i].op, rows[i].idx, rows[i].tgt, rows[i].last, rows[i].addr,
                   rows[i].typed, rows[i].res);

    // Overfill the staging store; the extra elements are dropped
    for (int k = 0; k < VectorMax + 3; k++)
      send_random(OP_LOAD, k, k == VectorMax + 2, 0);

    // Random vectors with interleaved reads
    for (int n = 0; n < 2000; ) begin
      if (n > 600 && !drained) begin
        // Hold for the receiver to drain before the next vector
        in_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      if (n > 1000 && !long_hold_req) long_hold_req = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                           : $urandom_range(0, top_slot + 2);
        send_random(OP_READ, $urandom_range(0, 4095), 1'($urandom_range(0, 1)), addr);
        n++;
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
          send_random(OP_LOAD, idx, k == len - 1, $urandom_range(0, 32767));
          n++;
        end
      end
    end
    send_random(OP_READ, 0, 1'b0, 0);
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d placements (%0d overflowed) and %0d slot reads,",
             n_place, n_ovf, n_read);
    $display("with staging overflow, repeated indices and a long receiver hold.");
    if (errs == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/svtp_pkg.sv
sv/svtp_slot_ram.sv
sv/sparse_vector_table_packer_top.sv
test/sparse_vector_table_packer_top_tb.sv
